FILE: design/txc_pkg.sv
// Package for the text console writer: command and character codes,
// field widths and the default screen geometry.
// Depends on nothing; used by text_console_writer.
package txc_pkg;

    // Default geometry
    localparam int COLUMNS_DEF    = 80;
    localparam int ROWS_DEF       = 25;
    localparam int TAB_SPACES_DEF = 4;

    // Fixed field widths of the ports
    localparam int CMD_W       = 2;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int READ_ROW_W  = 5;
    localparam int READ_COL_W  = 7;
    localparam int CUR_ROW_W   = 5;
    localparam int CUR_COL_W   = 7;
    localparam int CELL_W      = CHAR_W + ATTR_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Character codes with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Attribute after reset and after a clear
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

endpackage

FILE: design/text_console_writer.sv
// Text console writer: character-cell screen store, cursor and command sequencer.
// Depends on txc_pkg for codes, field widths and default geometry.
//
// Text-mode console engine. The screen is ROWS x COLUMNS cells held in one
// synchronous single-write, single-read memory; each cell is a character byte
// (low) and an attribute byte (high). Commands: put character (line feed,
// carriage return, tab as TAB_SPACES spaces, code 0 ignored, anything else is
// written at the cursor after a wrap if the row is full), clear screen (also
// returns the attribute to 7) and read one cell. Every command returns one
// result carrying the cursor after the command; cell_char and cell_attr are
// zero except for an in-range read. A carriage return, an ignored code or an
// unused command goes straight to the result; an ordinary character or a tab's
// spaces are written through the one memory write port, which takes one cell
// per cycle, and a read waits for the registered memory data. A character or
// tab space that meets a full row first wraps. A line advance on the bottom row
// scrolls the store, a copy sweep over all ROWS*COLUMNS cells (read one row
// ahead, write back in the next cycle), added once to every put that wraps or
// feeds past the bottom row. Clear is a fill sweep over all cells. After reset
// the same fill sweep runs over all ROWS*COLUMNS cells (2000 by default) with
// in_ready low; text_attribute writes are taken throughout. One item is in
// work at a time; a finished result waits in the output register while the
// next transaction is accepted.
module text_console_writer #(
    parameter int COLUMNS    = txc_pkg::COLUMNS_DEF,
    parameter int ROWS       = txc_pkg::ROWS_DEF,
    parameter int TAB_SPACES = txc_pkg::TAB_SPACES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Attribute register write
    input  logic                               text_attribute_we,
    input  logic [txc_pkg::ATTR_W-1:0]         text_attribute,

    // Command channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [txc_pkg::CMD_W-1:0]          cmd,
    input  logic [txc_pkg::CHAR_W-1:0]         char_code,
    input  logic [txc_pkg::READ_ROW_W-1:0]     read_row,
    input  logic [txc_pkg::READ_COL_W-1:0]     read_col,

    // Result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [txc_pkg::CHAR_W-1:0]         cell_char,
    output logic [txc_pkg::ATTR_W-1:0]         cell_attr,
    output logic [txc_pkg::CUR_ROW_W-1:0]      cursor_row,
    output logic [txc_pkg::CUR_COL_W-1:0]      cursor_col
);

    localparam int NCELLS = ROWS * COLUMNS;
    localparam int AW     = $clog2(NCELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLUMNS + 1);
    localparam int TW     = $clog2(TAB_SPACES + 1);
    localparam int CELL_W = txc_pkg::CELL_W;

    localparam logic [AW-1:0] LAST_CELL   = AW'(NCELLS - 1);
    localparam logic [AW-1:0] COPY_END    = AW'(NCELLS - COLUMNS);
    localparam logic [AW:0]   NCELLS_X    = (AW + 1)'(NCELLS);
    localparam logic [RW-1:0] BOTTOM_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] FULL_COL    = CW'(COLUMNS);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PUT    = 3'd1;
    localparam logic [2:0] S_SPRIME = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_RDATA  = 3'd4;
    localparam logic [2:0] S_FILL   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // Screen store
    logic [CELL_W-1:0] mem [NCELLS];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    // Control state
    logic [2:0]                    state_reg, state_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [RW-1:0]                 row_reg, row_next;
    logic [CW-1:0]                 col_reg, col_next;
    logic [txc_pkg::ATTR_W-1:0]    attr_reg, attr_next;
    logic                          scroll_to_put_reg, scroll_to_put_next;
    logic                          clear_pend_reg, clear_pend_next;
    logic                          out_valid_reg, out_valid_next;

    // Payload state
    logic [TW-1:0]                 cnt_reg, cnt_next;
    logic [txc_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic                          rd_ok_reg, rd_ok_next;
    logic [CELL_W-1:0]             res_reg, res_next;
    logic [txc_pkg::CHAR_W-1:0]    cell_char_reg, cell_char_next;
    logic [txc_pkg::ATTR_W-1:0]    cell_attr_reg, cell_attr_next;
    logic [txc_pkg::CUR_ROW_W-1:0] cursor_row_reg, cursor_row_next;
    logic [txc_pkg::CUR_COL_W-1:0] cursor_col_reg, cursor_col_next;

    logic [AW-1:0] cur_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_in_range;
    logic [AW:0]   scroll_src;
    logic          out_free;
    logic [CELL_W-1:0] blank_cell;

    assign cur_addr    = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign rd_addr     = AW'(read_row) * AW'(COLUMNS) + AW'(read_col);
    assign rd_in_range = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);
    assign scroll_src  = (AW + 1)'(ptr_reg) + (AW + 1)'(COLUMNS + 1);
    assign out_free    = !out_valid_reg || out_ready;
    assign blank_cell  = {attr_reg, txc_pkg::CH_SPACE};

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign cell_char  = cell_char_reg;
    assign cell_attr  = cell_attr_reg;
    assign cursor_row = cursor_row_reg;
    assign cursor_col = cursor_col_reg;

    // Memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        ptr_next           = ptr_reg;
        row_next           = row_reg;
        col_next           = col_reg;
        attr_next          = attr_reg;
        scroll_to_put_next = scroll_to_put_reg;
        clear_pend_next    = clear_pend_reg;
        out_valid_next     = out_valid_reg;
        cnt_next           = cnt_reg;
        char_next          = char_reg;
        rd_ok_next         = rd_ok_reg;
        res_next           = res_reg;
        cell_char_next     = cell_char_reg;
        cell_attr_next     = cell_attr_reg;
        cursor_row_next    = cursor_row_reg;
        cursor_col_next    = cursor_col_reg;

        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = blank_cell;
        mem_re    = 1'b0;
        mem_raddr = rd_addr;

        // Drop the held result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next = '0;
                    unique case (cmd)
                        txc_pkg::CMD_PUT:
                        begin
                            char_next = char_code;
                            cnt_next  = TW'(1);
                            priority if (char_code == txc_pkg::CH_LF)
                            begin
                                col_next = '0;
                                if (row_reg < BOTTOM_ROW)
                                begin
                                    row_next   = row_reg + RW'(1);
                                    state_next = S_DONE;
                                end
                                else
                                begin
                                    scroll_to_put_next = 1'b0;
                                    state_next         = S_SPRIME;
                                end
                            end
                            else if (char_code == txc_pkg::CH_CR)
                            begin
                                col_next   = '0;
                                state_next = S_DONE;
                            end
                            else if (char_code == txc_pkg::CH_TAB)
                            begin
                                char_next  = txc_pkg::CH_SPACE;
                                cnt_next   = TW'(TAB_SPACES);
                                state_next = S_PUT;
                            end
                            else if (char_code == txc_pkg::CH_NUL)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_PUT;
                            end
                        end
                        txc_pkg::CMD_CLEAR:
                        begin
                            attr_next       = txc_pkg::ATTR_RESET;
                            row_next        = '0;
                            col_next        = '0;
                            ptr_next        = '0;
                            clear_pend_next = 1'b1;
                            state_next      = S_FILL;
                        end
                        txc_pkg::CMD_READ:
                        begin
                            mem_re     = rd_in_range;
                            mem_raddr  = rd_addr;
                            rd_ok_next = rd_in_range;
                            state_next = S_RDATA;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_PUT:
            begin
                if (col_reg == FULL_COL)
                begin
                    // Wrap before writing
                    col_next = '0;
                    if (row_reg < BOTTOM_ROW)
                    begin
                        row_next = row_reg + RW'(1);
                    end
                    else
                    begin
                        scroll_to_put_next = 1'b1;
                        state_next         = S_SPRIME;
                    end
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_addr;
                    mem_wdata = {attr_reg, char_reg};
                    col_next  = col_reg + CW'(1);
                    cnt_next  = cnt_reg - TW'(1);
                    if (cnt_reg == TW'(1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SPRIME:
            begin
                // Prime the copy with the first cell of the second row
                mem_re     = 1'b1;
                mem_raddr  = AW'(COLUMNS);
                ptr_next   = '0;
                state_next = S_SCROLL;
            end
            S_SCROLL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = (ptr_reg < COPY_END) ? mem_rdata : blank_cell;
                if (scroll_src < NCELLS_X)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(scroll_src);
                end
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = scroll_to_put_reg ? S_PUT : S_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            S_RDATA:
            begin
                res_next   = rd_ok_reg ? mem_rdata : '0;
                state_next = S_DONE;
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = {txc_pkg::ATTR_RESET, txc_pkg::CH_SPACE};
                if (ptr_reg == LAST_CELL)
                begin
                    clear_pend_next = 1'b0;
                    state_next      = clear_pend_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    cell_char_next  = res_reg[txc_pkg::CHAR_W-1:0];
                    cell_attr_next  = res_reg[CELL_W-1:txc_pkg::CHAR_W];
                    cursor_row_next = txc_pkg::CUR_ROW_W'(row_reg);
                    cursor_col_next = txc_pkg::CUR_COL_W'(col_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (text_attribute_we)
        begin
            attr_next = text_attribute;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_FILL;
            ptr_reg           <= '0;
            row_reg           <= '0;
            col_reg           <= '0;
            attr_reg          <= txc_pkg::ATTR_RESET;
            scroll_to_put_reg <= 1'b0;
            clear_pend_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            ptr_reg           <= ptr_next;
            row_reg           <= row_next;
            col_reg           <= col_next;
            attr_reg          <= attr_next;
            scroll_to_put_reg <= scroll_to_put_next;
            clear_pend_reg    <= clear_pend_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        char_reg       <= char_next;
        rd_ok_reg      <= rd_ok_next;
        res_reg        <= res_next;
        cell_char_reg  <= cell_char_next;
        cell_attr_reg  <= cell_attr_next;
        cursor_row_reg <= cursor_row_next;
        cursor_col_reg <= cursor_col_next;
    end

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("store written while idle");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= FULL_COL)
        else $error("cursor column beyond row end");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= BOTTOM_ROW)
        else $error("cursor row beyond bottom row");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same cell in one cycle");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while one is in work");
`endif

endmodule
